[sv/pcrl_pkg.sv]
// Package for the point cloud radius layering block: word types, widths, codes.
// No dependencies; used by point_cloud_radius_layering.
package pcrl_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 24;
  localparam int INDEX_W        = 10;
  localparam int LAYER_W        = 11;
  localparam int DIST_W         = 20;
  localparam int CFG_W          = 20;
  localparam int SQ_W           = 2 * DIST_W;

  // largest positive coordinate, start value of the lowest-z search
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  localparam logic [CFG_W-1:0] RADIUS_RESET = CFG_W'(1000);
  localparam logic [CFG_W-1:0] BAND_RESET   = CFG_W'(100);

  // configuration register indexes
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_BAND   = 1'b1;

  // command and reply codes
  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_READ     = 1'b1;
  localparam logic REPLY_FINISH = 1'b0;
  localparam logic REPLY_READ   = 1'b1;

  // per-point visit status
  localparam logic [1:0] ST_UNVISITED = 2'd0;
  localparam logic [1:0] ST_PENDING   = 2'd1;
  localparam logic [1:0] ST_WAVE      = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  typedef struct packed {
    logic                      cmd;
    logic [INDEX_W-1:0]        point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      final_point;
  } item_t;

  typedef struct packed {
    logic               reply_kind;
    logic [INDEX_W-1:0] reply_index;
    logic [LAYER_W-1:0] layer_number;
    logic [DIST_W-1:0]  parent_distance;
    logic               distance_valid;
  } result_t;

endpackage

[sv/point_cloud_radius_layering.sv]
// Point cloud radius layering: point store, breadth-first layering sequencer
// with one shared squaring multiplier, and a bit-serial square root. Uses pcrl_pkg.
//
// A load word is taken while idle. A read word replies directly when the index is
// at or beyond the point count, after the layer read when the point has no valid
// distance, else after the square root (one root bit per cycle). The word
// that carries final_point starts the layering pass; busy stays high until the
// finish word. The pass runs the lowest-z and seeding scans, then per wave and
// per parent skips each candidate outside the radius box or already in a wave
// or retired, and squares the offsets of each one inside the box through the one
// squaring multiplier; waves end with a pass over their members. Results appear on
// result for one cycle with result_valid high; the receiver cannot stall them,
// so it must take every result word as it comes.
module point_cloud_radius_layering #(
  parameter int MAX_POINTS = pcrl_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  pcrl_pkg::item_t            item,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pcrl_pkg::CFG_W-1:0] cfg_data,
  output logic                       result_valid,
  output pcrl_pkg::result_t          result
);

  localparam int IW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = pcrl_pkg::COORD_W;
  localparam int LW    = pcrl_pkg::LAYER_W;
  localparam int DW    = pcrl_pkg::DIST_W;
  localparam int SQW   = pcrl_pkg::SQ_W;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RDWAIT  = 5'd1;
  localparam logic [4:0] S_SQRT    = 5'd2;
  localparam logic [4:0] S_R2A     = 5'd3;
  localparam logic [4:0] S_R2B     = 5'd4;
  localparam logic [4:0] S_MZ_RD   = 5'd5;
  localparam logic [4:0] S_MZ_CMP  = 5'd6;
  localparam logic [4:0] S_IN_RD   = 5'd7;
  localparam logic [4:0] S_IN_UPD  = 5'd8;
  localparam logic [4:0] S_CHK     = 5'd9;
  localparam logic [4:0] S_RS_RD   = 5'd10;
  localparam logic [4:0] S_RS_TST  = 5'd11;
  localparam logic [4:0] S_WV_LRD  = 5'd12;
  localparam logic [4:0] S_WV_PRD  = 5'd13;
  localparam logic [4:0] S_WV_PLAT = 5'd14;
  localparam logic [4:0] S_J_RD    = 5'd15;
  localparam logic [4:0] S_J_DIFF  = 5'd16;
  localparam logic [4:0] S_J_MX    = 5'd17;
  localparam logic [4:0] S_J_MY    = 5'd18;
  localparam logic [4:0] S_J_MZ    = 5'd19;
  localparam logic [4:0] S_J_SUM   = 5'd20;
  localparam logic [4:0] S_J_UPD   = 5'd21;
  localparam logic [4:0] S_DN_RD   = 5'd22;
  localparam logic [4:0] S_DN_WR   = 5'd23;
  localparam logic [4:0] S_PN_RD   = 5'd24;
  localparam logic [4:0] S_PN_WR   = 5'd25;
  localparam logic [4:0] S_FIN     = 5'd26;

  // memories
  logic signed [CW-1:0] x_mem [MAX_POINTS];
  logic signed [CW-1:0] y_mem [MAX_POINTS];
  logic signed [CW-1:0] z_mem [MAX_POINTS];
  logic [LW-1:0]        layer_mem [MAX_POINTS];
  logic [SQW:0]         best_mem [MAX_POINTS];
  logic [1:0]           stat_mem [MAX_POINTS];
  logic [IW-1:0]        list_mem [2*MAX_POINTS];

  logic signed [CW-1:0] x_q, y_q, z_q;
  logic [LW-1:0]        layer_q;
  logic [SQW:0]         best_q;
  logic [1:0]           stat_q;
  logic [IW-1:0]        list_q;

  // control and datapath registers
  logic [4:0]           state;
  logic [DW-1:0]        radius, band;
  logic [CNT_W-1:0]     count, ii, kk, cur, nxt, visited, rs, wc, top;
  logic                 cb;
  logic signed [CW-1:0] minz, px, py, pz;
  logic signed [CW+1:0] thr;
  logic [SQW-1:0]       r2, prod;
  logic [SQW+1:0]       acc;
  logic [DW-1:0]        dx, dy, dz;
  logic [1:0]           st_l;
  logic [SQW:0]         best_l;
  logic [SQW-1:0]       sq_val;
  logic [DW+2:0]        rem;
  logic [DW-1:0]        root;
  logic [4:0]           sc;

  // combinational helpers
  logic [DW-1:0]        mul_a;
  logic                 idx_ok, rd_ok;
  logic [IW-1:0]        c_ra, lb_ra, st_ra;
  logic [IW:0]          l_ra;
  logic                 c_we, st_we, layer_we, best_we, l_we;
  logic [IW-1:0]        st_wa, lb_wa;
  logic [IW:0]          l_wa;
  logic [1:0]           st_wd;
  logic [LW-1:0]        layer_wd;
  logic [SQW:0]         best_wd;
  logic [IW-1:0]        l_wd;
  logic [CW:0]          adx, ady, adz;
  logic signed [CW:0]   ddx, ddy, ddz;
  logic                 in_box, skip_st;
  logic signed [CW-1:0] minz_next;
  logic signed [CW+1:0] z_ext;
  logic                 seed_hit, link_hit, j_new, j_better;
  logic [DW+2:0]        rem_sh, trial;
  logic                 last_j;

  assign busy   = (state != S_IDLE);
  assign idx_ok = ({22'd0, item.point_index} < 32'(MAX_POINTS));
  assign rd_ok  = idx_ok && ({22'd0, item.point_index} < 32'(count));

  // read address selection
  assign c_ra  = (state == S_WV_PRD) ? list_q : ii[IW-1:0];
  assign lb_ra = (state == S_IDLE) ? IW'(item.point_index) : ii[IW-1:0];
  assign st_ra = ii[IW-1:0];
  assign l_ra  = (state == S_PN_RD) ? {~cb, kk[IW-1:0]} : {cb, kk[IW-1:0]};

  // candidate distance tests
  assign ddx = $signed({x_q[CW-1], x_q}) - $signed({px[CW-1], px});
  assign ddy = $signed({y_q[CW-1], y_q}) - $signed({py[CW-1], py});
  assign ddz = $signed({z_q[CW-1], z_q}) - $signed({pz[CW-1], pz});
  assign adx = ddx[CW] ? (CW+1)'(-ddx) : ddx;
  assign ady = ddy[CW] ? (CW+1)'(-ddy) : ddy;
  assign adz = ddz[CW] ? (CW+1)'(-ddz) : ddz;
  assign in_box = (adx <= (CW+1)'(radius)) && (ady <= (CW+1)'(radius)) &&
                  (adz <= (CW+1)'(radius));
  assign skip_st = (stat_q == pcrl_pkg::ST_WAVE) || (stat_q == pcrl_pkg::ST_DONE);

  assign minz_next = (z_q < minz) ? z_q : minz;
  assign z_ext     = {{2{z_q[CW-1]}}, z_q};
  assign seed_hit  = (state == S_IN_UPD) && (z_ext <= thr);
  assign link_hit  = (state == S_RS_TST) && (stat_q == pcrl_pkg::ST_UNVISITED);
  assign j_new     = (state == S_J_UPD) && (acc <= (SQW+2)'(r2)) &&
                     (st_l == pcrl_pkg::ST_UNVISITED);
  assign j_better  = (state == S_J_UPD) && (acc <= (SQW+2)'(r2)) &&
                     (st_l != pcrl_pkg::ST_UNVISITED) &&
                     ({1'b0, acc[SQW-1:0]} < best_l);
  assign last_j    = (ii + 1'b1 >= count);

  // square root step: two radicand bits per cycle
  assign rem_sh = {rem[DW:0], sq_val[SQW-1:SQW-2]};
  assign trial  = {1'b0, root, 2'b01};

  // shared squaring multiplier operand
  always_comb begin
    unique case (state)
      S_J_MX:  mul_a = dx;
      S_J_MY:  mul_a = dy;
      S_J_MZ:  mul_a = dz;
      default: mul_a = radius;
    endcase
  end

  // memory write controls
  always_comb begin
    c_we     = (state == S_IDLE) && start && (item.cmd == pcrl_pkg::CMD_LOAD) && idx_ok;
    st_we    = 1'b0;
    st_wa    = ii[IW-1:0];
    st_wd    = pcrl_pkg::ST_UNVISITED;
    layer_we = 1'b0;
    best_we  = 1'b0;
    lb_wa    = ii[IW-1:0];
    layer_wd = LW'(wc);
    best_wd  = {1'b0, acc[SQW-1:0]};
    l_we     = 1'b0;
    l_wa     = {cb, cur[IW-1:0]};
    l_wd     = ii[IW-1:0];
    if (state == S_IN_UPD) begin
      st_we = 1'b1;
      if (seed_hit) begin
        st_wd    = pcrl_pkg::ST_WAVE;
        layer_we = 1'b1;
        best_we  = 1'b1;
        layer_wd = LW'(1);
        best_wd  = '0;
        l_we     = 1'b1;
      end
    end
    if (link_hit) begin
      st_we    = 1'b1;
      st_wd    = pcrl_pkg::ST_WAVE;
      layer_we = 1'b1;
      best_we  = 1'b1;
      best_wd  = {1'b1, {SQW{1'b0}}};
      l_we     = 1'b1;
      l_wa     = {cb, {IW{1'b0}}};
    end
    if (j_new) begin
      st_we    = 1'b1;
      st_wd    = pcrl_pkg::ST_PENDING;
      layer_we = 1'b1;
      best_we  = 1'b1;
      l_we     = 1'b1;
      l_wa     = {~cb, nxt[IW-1:0]};
    end
    if (j_better) begin
      best_we = 1'b1;
    end
    if (state == S_DN_WR) begin
      st_we = 1'b1;
      st_wa = list_q;
      st_wd = pcrl_pkg::ST_DONE;
    end
    if (state == S_PN_WR) begin
      st_we = 1'b1;
      st_wa = list_q;
      st_wd = pcrl_pkg::ST_WAVE;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (c_we) begin
      x_mem[IW'(item.point_index)] <= item.coord_x;
      y_mem[IW'(item.point_index)] <= item.coord_y;
      z_mem[IW'(item.point_index)] <= item.coord_z;
    end
    x_q <= x_mem[c_ra];
    y_q <= y_mem[c_ra];
    z_q <= z_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (layer_we) begin
      layer_mem[lb_wa] <= layer_wd;
    end
    layer_q <= layer_mem[lb_ra];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[lb_wa] <= best_wd;
    end
    best_q <= best_mem[lb_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      stat_mem[st_wa] <= st_wd;
    end
    stat_q <= stat_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      list_mem[l_wa] <= l_wd;
    end
    list_q <= list_mem[l_ra];
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= SQW'(mul_a) * SQW'(mul_a);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= pcrl_pkg::RADIUS_RESET;
      band   <= pcrl_pkg::BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcrl_pkg::CFG_RADIUS: radius <= cfg_data;
        pcrl_pkg::CFG_BAND:   band   <= cfg_data;
        default:              radius <= radius;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      wc           <= CNT_W'(2);
      rs           <= '0;
      cb           <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (item.cmd == pcrl_pkg::CMD_LOAD) begin
              if (item.final_point) begin
                count <= idx_ok ? CNT_W'({22'd0, item.point_index} + 32'd1)
                                : CNT_W'(MAX_POINTS);
                ii    <= '0;
                minz  <= pcrl_pkg::COORD_MAX;
                top   <= '0;
                cur   <= '0;
                cb    <= 1'b0;
                state <= S_R2A;
              end
            end else begin
              result.reply_kind      <= pcrl_pkg::REPLY_READ;
              result.reply_index     <= item.point_index;
              result.layer_number    <= '0;
              result.parent_distance <= '0;
              result.distance_valid  <= 1'b0;
              if (rd_ok) begin
                state <= S_RDWAIT;
              end else begin
                result_valid <= 1'b1;
              end
            end
          end
        end
        // read reply: layer known, root only when the distance is valid
        S_RDWAIT: begin
          result.layer_number <= layer_q;
          if (best_q[SQW]) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else begin
            sq_val <= best_q[SQW-1:0];
            rem    <= '0;
            root   <= '0;
            sc     <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_val <= {sq_val[SQW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[DW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[DW-2:0], 1'b0};
          end
          sc <= sc + 1'b1;
          if (sc == 5'(DW - 1)) begin
            result.parent_distance <= (rem_sh >= trial) ? {root[DW-2:0], 1'b1}
                                                        : {root[DW-2:0], 1'b0};
            result.distance_valid  <= 1'b1;
            result_valid           <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        // radius squared through the multiplier
        S_R2A: begin
          state <= S_R2B;
        end
        S_R2B: begin
          r2    <= prod;
          state <= S_MZ_RD;
        end
        // lowest z over the loaded points
        S_MZ_RD: begin
          state <= S_MZ_CMP;
        end
        S_MZ_CMP: begin
          minz <= minz_next;
          if (last_j) begin
            thr   <= $signed({{2{minz_next[CW-1]}}, minz_next}) +
                     $signed({{(CW+2-DW){1'b0}}, band});
            ii    <= '0;
            state <= S_IN_RD;
          end else begin
            ii    <= ii + 1'b1;
            state <= S_MZ_RD;
          end
        end
        // seed layer one, mark every other point unvisited
        S_IN_RD: begin
          state <= S_IN_UPD;
        end
        S_IN_UPD: begin
          if (seed_hit) begin
            cur <= cur + 1'b1;
            top <= (top > CNT_W'(1)) ? top : CNT_W'(1);
          end
          if (last_j) begin
            visited <= seed_hit ? cur + 1'b1 : cur;
            wc      <= CNT_W'(2);
            rs      <= '0;
            state   <= S_CHK;
          end else begin
            ii    <= ii + 1'b1;
            state <= S_IN_RD;
          end
        end
        // next wave, a restart, or the end of the pass
        S_CHK: begin
          nxt <= '0;
          kk  <= '0;
          if (visited >= count) begin
            state <= S_FIN;
          end else if (cur == '0) begin
            if (rs >= count) begin
              state <= S_FIN;
            end else begin
              ii    <= rs;
              state <= S_RS_RD;
            end
          end else begin
            state <= S_WV_LRD;
          end
        end
        S_RS_RD: begin
          state <= S_RS_TST;
        end
        S_RS_TST: begin
          if (link_hit) begin
            cur     <= CNT_W'(1);
            visited <= visited + 1'b1;
            rs      <= ii + 1'b1;
            top     <= (top > wc) ? top : wc;
            kk      <= '0;
            state   <= S_WV_LRD;
          end else if (last_j) begin
            state <= S_FIN;
          end else begin
            ii    <= ii + 1'b1;
            state <= S_RS_RD;
          end
        end
        // fetch one parent of the wave
        S_WV_LRD: begin
          state <= S_WV_PRD;
        end
        S_WV_PRD: begin
          state <= S_WV_PLAT;
        end
        S_WV_PLAT: begin
          px    <= x_q;
          py    <= y_q;
          pz    <= z_q;
          ii    <= '0;
          state <= S_J_RD;
        end
        // scan all candidates against this parent
        S_J_RD: begin
          state <= S_J_DIFF;
        end
        S_J_DIFF: begin
          st_l   <= stat_q;
          best_l <= best_q;
          dx     <= DW'(adx);
          dy     <= DW'(ady);
          dz     <= DW'(adz);
          if (!skip_st && in_box) begin
            state <= S_J_MX;
          end else if (!last_j) begin
            ii    <= ii + 1'b1;
            state <= S_J_RD;
          end else if (kk + 1'b1 < cur) begin
            kk    <= kk + 1'b1;
            state <= S_WV_LRD;
          end else begin
            kk    <= '0;
            state <= S_DN_RD;
          end
        end
        S_J_MX: begin
          state <= S_J_MY;
        end
        S_J_MY: begin
          acc   <= (SQW+2)'(prod);
          state <= S_J_MZ;
        end
        S_J_MZ: begin
          acc   <= acc + (SQW+2)'(prod);
          state <= S_J_SUM;
        end
        S_J_SUM: begin
          acc   <= acc + (SQW+2)'(prod);
          state <= S_J_UPD;
        end
        S_J_UPD: begin
          if (j_new) begin
            nxt     <= nxt + 1'b1;
            visited <= visited + 1'b1;
            top     <= (top > wc) ? top : wc;
          end
          if (!last_j) begin
            ii    <= ii + 1'b1;
            state <= S_J_RD;
          end else if (kk + 1'b1 < cur) begin
            kk    <= kk + 1'b1;
            state <= S_WV_LRD;
          end else begin
            kk    <= '0;
            state <= S_DN_RD;
          end
        end
        // retire the finished wave
        S_DN_RD: begin
          state <= S_DN_WR;
        end
        S_DN_WR: begin
          if (kk + 1'b1 < cur) begin
            kk    <= kk + 1'b1;
            state <= S_DN_RD;
          end else if (nxt == '0) begin
            cur   <= '0;
            state <= S_CHK;
          end else begin
            kk    <= '0;
            state <= S_PN_RD;
          end
        end
        // promote the new wave
        S_PN_RD: begin
          state <= S_PN_WR;
        end
        S_PN_WR: begin
          if (kk + 1'b1 < nxt) begin
            kk    <= kk + 1'b1;
            state <= S_PN_RD;
          end else begin
            cb    <= ~cb;
            cur   <= nxt;
            if (wc < CNT_W'(MAX_POINTS)) begin
              wc <= wc + 1'b1;
            end
            state <= S_CHK;
          end
        end
        S_FIN: begin
          result.reply_kind      <= pcrl_pkg::REPLY_FINISH;
          result.reply_index     <= pcrl_pkg::INDEX_W'(count - 1'b1);
          result.layer_number    <= LW'(top);
          result.parent_distance <= '0;
          result.distance_valid  <= 1'b0;
          result_valid           <= 1'b1;
          state                  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
